// File: rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Capacity, codes for the operation and the status, and the control bundle
// that the top level broadcasts to every cell of the shift array.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH   = 128;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int PRIO_W  = 8;
  localparam int VALUE_W = 32;
  localparam int FILL_W  = 8;
  localparam int STAT_W  = 2;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_DELETE = 1'b1
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // broadcast to all cells in the cycle an operation is taken
  typedef struct packed {
    logic                      ins_en;
    logic                      del_en;
    logic [PRIO_W-1:0]         prio;
    logic signed [VALUE_W-1:0] value;
  } spq_ctrl_t;

endpackage

// File: rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift array
// Holds one priority and value. On insert it keeps its entry, takes the new
// entry or takes its left neighbor; on delete it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic                      clk,
  input  spq_ctrl_t                 ctrl,
  input  logic                      occupied,
  input  logic                      left_after,
  input  logic [PRIO_W-1:0]         left_prio,
  input  logic signed [VALUE_W-1:0] left_value,
  input  logic [PRIO_W-1:0]         right_prio,
  input  logic signed [VALUE_W-1:0] right_value,
  output logic                      after,
  output logic [PRIO_W-1:0]         prio,
  output logic signed [VALUE_W-1:0] value
);

  logic [PRIO_W-1:0]         prio_next;
  logic signed [VALUE_W-1:0] value_next;

  // new entry goes at or before this slot: free slot or strictly lower priority
  assign after = !occupied || (prio < ctrl.prio);

  always_comb begin
    prio_next  = prio;
    value_next = value;
    if (ctrl.del_en) begin
      prio_next  = right_prio;
      value_next = right_value;
    end else if (ctrl.ins_en && after) begin
      if (left_after) begin
        prio_next  = left_prio;
        value_next = left_value;
      end else begin
        prio_next  = ctrl.prio;
        value_next = ctrl.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    prio  <= prio_next;
    value <= value_next;
  end

endmodule

// File: rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue: fixed-capacity priority queue as a sorted shift array
// The result of each input transfer is registered in the output register.
// Throughput: one operation per cycle while not stalled; every cell compares
// and shifts at once. A stalled result blocks new input only while the
// output register is full. Reset clears the entry count and the output valid;
// slot contents are not cleared, slots at or beyond the count are never read.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // prio_in[7:0], value_in[39:8]
  input  logic        s_axis_tuser,   // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // value_out[31:0], fill_level[39:32]
  output logic [1:0]  m_axis_tuser    // status
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             take;
  logic             is_ins;
  logic             full;
  logic             empty;
  spq_ctrl_t        ctrl;
  status_t          status_next;
  logic signed [VALUE_W-1:0] value_out_next;

  logic [DEPTH-1:0]                after;
  logic [DEPTH-1:0]                occ;
  logic [PRIO_W-1:0]               cprio  [DEPTH];
  logic signed [VALUE_W-1:0]       cvalue [DEPTH];

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  status_t                   out_status;
  logic [FILL_W-1:0]         out_fill;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign take   = s_axis_tvalid && s_axis_tready;
  assign is_ins = (action_t'(s_axis_tuser) == ACT_INSERT);
  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);

  assign ctrl.ins_en = take && is_ins && !full;
  assign ctrl.del_en = take && !is_ins && !empty;
  assign ctrl.prio   = s_axis_tdata[PRIO_W-1:0];
  assign ctrl.value  = s_axis_tdata[PRIO_W +: VALUE_W];

  always_comb begin
    count_next     = count;
    status_next    = ST_OK;
    value_out_next = '0;
    if (is_ins) begin
      if (full) status_next = ST_OVERFLOW;
      else      count_next  = count + CNT_W'(1);
    end else begin
      if (empty) begin
        status_next = ST_UNDERFLOW;
      end else begin
        count_next     = count - CNT_W'(1);
        value_out_next = cvalue[0];
      end
    end
  end

  genvar i;
  generate
    for (i = 0; i < DEPTH; i++) begin : g_cell
      logic                      l_after;
      logic [PRIO_W-1:0]         l_prio;
      logic signed [VALUE_W-1:0] l_value;
      logic [PRIO_W-1:0]         r_prio;
      logic signed [VALUE_W-1:0] r_value;

      assign occ[i] = (CNT_W'(i) < count);

      if (i == 0) begin : g_head
        assign l_after = 1'b0;
        assign l_prio  = '0;
        assign l_value = '0;
      end else begin : g_body
        assign l_after = after[i-1];
        assign l_prio  = cprio[i-1];
        assign l_value = cvalue[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign r_prio  = '0;
        assign r_value = '0;
      end else begin : g_next
        assign r_prio  = cprio[i+1];
        assign r_value = cvalue[i+1];
      end

      spq_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (occ[i]),
        .left_after  (l_after),
        .left_prio   (l_prio),
        .left_value  (l_value),
        .right_prio  (r_prio),
        .right_value (r_value),
        .after       (after[i]),
        .prio        (cprio[i]),
        .value       (cvalue[i])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_value  <= value_out_next;
      out_status <= status_next;
      out_fill   <= FILL_W'(count_next);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_fill, out_value};
  assign m_axis_tuser  = out_status;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("entry count beyond capacity");

  a_overflow: assert property (@(posedge clk) disable iff (rst)
    (take && is_ins && full) |=> (out_status == ST_OVERFLOW && count == $past(count)))
    else $error("insert into full queue not refused");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status == ST_UNDERFLOW) |-> (out_fill == '0 && out_value == '0))
    else $error("underflow result not empty");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.ins_en |=> (count == $past(count) + CNT_W'(1)))
    else $error("insert did not grow count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!take) |=> (count == $past(count)))
    else $error("count changed without a transfer");

endmodule
